/* hdl/depth_minmax_gray_remap_defines.svh */
// ----------------------------------------------------------------------------
// Depth min/max gray remap assertion macros
// Shared helpers for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef DEPTH_MINMAX_GRAY_REMAP_DEFINES_SVH
`define DEPTH_MINMAX_GRAY_REMAP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dmg_pkg.sv */
// ----------------------------------------------------------------------------
// Depth min/max gray remap package
// Operation codes and fixed constants shared by the remap modules.
// ----------------------------------------------------------------------------
package dmg_pkg;

	// Request operation codes.
	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_MAP  = 1'b1
	} op_t;

	// Brightest gray level, also the scale factor of the normalization.
	localparam logic [7:0] GRAY_TOP = 8'd255;

	// Gray level of an empty sample or a sample at or above the maximum.
	localparam logic [7:0] GRAY_ZERO = 8'd0;

	// Quotient bits produced by the divider, one per step.
	localparam int unsigned DIV_STEPS = 8;

endpackage

/* hdl/dmg_queue.sv */
// ----------------------------------------------------------------------------
// Depth min/max gray remap job queue
// Small register FIFO that decouples the classifier from the divider.
// ----------------------------------------------------------------------------
module dmg_queue #(
	parameter int unsigned WIDTH = 41,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/dmg_front.sv */
// ----------------------------------------------------------------------------
// Depth min/max gray remap front end
// Tracks the depth range on scan requests and classifies map requests.
// ----------------------------------------------------------------------------
module dmg_front #(
	parameter int unsigned DEPTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic                  operation,
	input  logic                  first,
	input  logic [DEPTH_BITS-1:0] depth,
	output logic                  job_valid,
	input  logic                  job_ready,
	output logic                  job_direct,
	output logic [7:0]            job_value,
	output logic [DEPTH_BITS-1:0] job_diff,
	output logic [DEPTH_BITS-1:0] job_span
);

	logic [DEPTH_BITS-1:0] low_seen_q;
	logic [DEPTH_BITS-1:0] high_seen_q;
	logic [DEPTH_BITS-1:0] low_base;
	logic [DEPTH_BITS-1:0] high_base;
	logic                  is_map;
	logic                  scan_take;

	assign is_map     = (operation == dmg_pkg::OP_MAP);
	assign item_ready = job_ready;
	assign job_valid  = item_valid && is_map;
	assign scan_take  = item_valid && item_ready && !is_map;

	// A restart takes effect before the sample of the same request.
	assign low_base  = first ? '1 : low_seen_q;
	assign high_base = first ? '0 : high_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_seen_q  <= '1;
			high_seen_q <= '0;
		end else if (scan_take) begin
			low_seen_q  <= ((depth != '0) && (depth < low_base)) ? depth : low_base;
			high_seen_q <= ((depth != '0) && (depth > high_base)) ? depth : high_base;
		end
	end

	always_comb begin
		job_direct = 1'b1;
		job_value  = dmg_pkg::GRAY_ZERO;
		job_diff   = depth - low_seen_q;
		job_span   = high_seen_q - low_seen_q;
		priority if (depth == '0) begin
			job_value = dmg_pkg::GRAY_ZERO;
		end else if (high_seen_q <= low_seen_q) begin
			job_value = dmg_pkg::GRAY_TOP;
		end else if (depth <= low_seen_q) begin
			job_value = dmg_pkg::GRAY_TOP;
		end else if (depth >= high_seen_q) begin
			job_value = dmg_pkg::GRAY_ZERO;
		end else begin
			job_direct = 1'b0;
		end
	end

endmodule

/* hdl/dmg_back.sv */
// ----------------------------------------------------------------------------
// Depth min/max gray remap back end
// Restoring divider for the scaled offset and the result register.
// ----------------------------------------------------------------------------
module dmg_back #(
	parameter int unsigned DEPTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  logic                  job_direct,
	input  logic [7:0]            job_value,
	input  logic [DEPTH_BITS-1:0] job_diff,
	input  logic [DEPTH_BITS-1:0] job_span,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [7:0]            gray
);

	localparam int unsigned CNT_W = $clog2(dmg_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(dmg_pkg::DIV_STEPS - 1);

	typedef enum logic [2:0] {
		BE_IDLE = 3'b001,
		BE_DIV  = 3'b010,
		BE_DONE = 3'b100
	} be_state_t;

	be_state_t               state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    result_valid_q;
	logic [7:0]              gray_q;
	logic                    direct_q;
	logic [7:0]              value_q;
	logic [DEPTH_BITS-1:0]   span_q;
	logic [DEPTH_BITS-1:0]   rem_q;
	logic [7:0]              low8_q;
	logic [7:0]              quo_q;
	logic [DEPTH_BITS+7:0]   scaled;
	logic [DEPTH_BITS:0]     trial;
	logic [DEPTH_BITS:0]     trial_sub;
	logic                    trial_fits;
	logic [7:0]              quo_ceil;
	logic                    take_job;
	logic                    out_free;

	assign job_ready    = (state_q == BE_IDLE);
	assign take_job     = job_valid && job_ready;
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign gray         = gray_q;

	// Offset times 255 as a shift and subtract.
	assign scaled = {job_diff, 8'b0} - {8'b0, job_diff};

	// One restoring step: bring down the next numerator bit and try the span.
	assign trial      = {rem_q, low8_q[7]};
	assign trial_sub  = trial - {1'b0, span_q};
	assign trial_fits = (trial >= {1'b0, span_q});

	// Round the quotient up when anything is left over.
	assign quo_ceil = quo_q + {7'b0, (rem_q != '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BE_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one being taken in the same cycle.
			if ((state_q == BE_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				BE_IDLE: begin
					if (take_job) begin
						cnt_q   <= '0;
						state_q <= job_direct ? BE_DONE : BE_DIV;
					end
				end
				BE_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= BE_DONE;
					end
				end
				BE_DONE: begin
					if (out_free) begin
						state_q <= BE_IDLE;
					end
				end
				default: begin
					state_q <= BE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_job) begin
			direct_q <= job_direct;
			value_q  <= job_value;
			span_q   <= job_span;
			rem_q    <= scaled[DEPTH_BITS+7:8];
			low8_q   <= scaled[7:0];
			quo_q    <= '0;
		end else if (state_q == BE_DIV) begin
			rem_q  <= trial_fits ? trial_sub[DEPTH_BITS-1:0] : trial[DEPTH_BITS-1:0];
			low8_q <= {low8_q[6:0], 1'b0};
			quo_q  <= {quo_q[6:0], trial_fits};
		end
		if ((state_q == BE_DONE) && out_free) begin
			gray_q <= direct_q ? value_q : dmg_pkg::GRAY_TOP - quo_ceil;
		end
	end

endmodule

/* hdl/depth_minmax_gray_remap.sv */
// ----------------------------------------------------------------------------
// Depth min/max gray remap
// Two-pass depth to inverted gray conversion with range tracking and divider.
// ----------------------------------------------------------------------------
// Scan requests give no result and are taken every cycle while the job queue has room.
// A map request inside the tracked range holds the divider through setup, eight
// restoring steps and output; other map requests skip the restoring steps. The divider
// takes no new job until the current one has reached its output register.
// Reset (arst_n low) empties the queue, idles the divider, drops any pending result and
// sets the tracked range to minimum all ones and maximum zero.
// ----------------------------------------------------------------------------
`include "depth_minmax_gray_remap_defines.svh"

module depth_minmax_gray_remap #(
	parameter int unsigned DEPTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic                  operation,
	input  logic                  first,
	input  logic [DEPTH_BITS-1:0] depth,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [7:0]            gray
);

	// A job is the direct flag, the direct gray value, the offset from the
	// minimum and the span of the tracked range.
	localparam int unsigned JOB_W = 1 + 8 + 2 * DEPTH_BITS;

	logic                  push_valid;
	logic                  push_ready;
	logic                  push_direct;
	logic [7:0]            push_value;
	logic [DEPTH_BITS-1:0] push_diff;
	logic [DEPTH_BITS-1:0] push_span;
	logic [JOB_W-1:0]      push_data;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [JOB_W-1:0]      pop_data;
	logic                  map_accept;
	logic                  scan_accept;

	// The front end updates the range on scan requests and turns each map
	// request into a job. Every empty, degenerate or out-of-range sample is
	// resolved here, so the back end divides only when the sample lies
	// strictly inside the tracked range.
	dmg_front #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation (operation),
		.first     (first),
		.depth     (depth),
		.job_valid (push_valid),
		.job_ready (push_ready),
		.job_direct(push_direct),
		.job_value (push_value),
		.job_diff  (push_diff),
		.job_span  (push_span)
	);

	assign push_data = {push_direct, push_value, push_diff, push_span};

	// The queue carries a snapshot of the range with each job, so scans that
	// follow a map request never disturb its result.
	dmg_queue #(
		.WIDTH(JOB_W),
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// The back end computes 255 - ceil(offset * 255 / span), or passes the direct
	// gray value, and holds the result in its output register until it is taken.
	dmg_back #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (pop_valid),
		.job_ready   (pop_ready),
		.job_direct  (pop_data[JOB_W-1]),
		.job_value   (pop_data[JOB_W-2 -: 8]),
		.job_diff    (pop_data[2*DEPTH_BITS-1 -: DEPTH_BITS]),
		.job_span    (pop_data[DEPTH_BITS-1:0]),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.gray        (gray)
	);

	assign map_accept  = item_valid && item_ready && (operation == dmg_pkg::OP_MAP);
	assign scan_accept = item_valid && item_ready && (operation == dmg_pkg::OP_SCAN);

	// A job enters the queue exactly when a map request is accepted.
	`DMG_ASSERT_NOW(a_push_on_map, 1'b1, (push_valid && push_ready) == map_accept, "job push mismatch")

	// Scan requests never create a job.
	`DMG_ASSERT_NOW(a_scan_no_job, scan_accept, !push_valid, "scan request produced a job")

	// Once the back end takes a job it is busy in the following cycle.
	`DMG_ASSERT_NEXT(a_back_busy, pop_valid && pop_ready, !pop_ready, "back end idle after a job")

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Depth min/max gray remap testbench
// Sends scan and map requests into depth_minmax_gray_remap with random gaps
// and output stalls. It predicts each gray level from a tracked depth range
// of its own and checks every result, in order, against that prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Number of requests after which the random frames stop.
	localparam int unsigned REQUEST_TARGET = 1700;
	// Cycles the receiver holds off during the backpressure test.
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	// Cycles to wait after the last result.
	localparam int unsigned DRAIN_CYCLES = 30;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic        operation;
	logic        first;
	logic [15:0] depth;
	logic        result_valid;
	logic        result_ready;
	logic [7:0]  gray;

	// Depth range as the block should be tracking it after every accepted request.
	logic [15:0] range_low = '1;
	logic [15:0] range_high = '0;

	// Gray levels of accepted map requests whose results have not come back yet.
	logic [7:0] pending_gray[$];

	int unsigned request_count = 0;
	int unsigned error_count = 0;
	// When set, neither side inserts idle cycles.
	bit no_idle = 1'b0;
	// The receiver counts this down, holding ready low, before idling at random again.
	int unsigned hold_left = 0;

	depth_minmax_gray_remap #(
		.DEPTH_BITS(16)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.first(first),
		.depth(depth),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.gray(gray)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Gray level for a sample against the current range: empty samples are
	// black, a degenerate or empty range and anything at or below the minimum
	// is white, anything at or above the maximum is black, and the rest is
	// the inverted, upward-rounded scale of the offset into the range.
	function automatic logic [7:0] gray_for_depth(logic [15:0] d);
		logic [31:0] span;
		logic [31:0] scaled;
		logic [31:0] steps;
		if (d == 16'd0)
			return dmg_pkg::GRAY_ZERO;
		if (range_high <= range_low)
			return dmg_pkg::GRAY_TOP;
		if (d <= range_low)
			return dmg_pkg::GRAY_TOP;
		if (d >= range_high)
			return dmg_pkg::GRAY_ZERO;
		span = 32'(range_high) - 32'(range_low);
		scaled = (32'(d) - 32'(range_low)) * 32'(dmg_pkg::GRAY_TOP);
		steps = (scaled + span - 32'd1) / span;
		if (steps > 32'(dmg_pkg::GRAY_TOP))
			steps = 32'(dmg_pkg::GRAY_TOP);
		return dmg_pkg::GRAY_TOP - steps[7:0];
	endfunction

	// Applies one accepted request to the tracked range, or queues its gray level.
	task automatic track_request(dmg_pkg::op_t op, logic restart, logic [15:0] d);
		if (op == dmg_pkg::OP_SCAN) begin
			// A restart happens even when the sample itself is empty.
			if (restart) begin
				range_low = '1;
				range_high = '0;
			end
			if (d != 16'd0) begin
				if (d < range_low)
					range_low = d;
				if (d > range_high)
					range_high = d;
			end
		end else begin
			// The first flag means nothing on a map request.
			pending_gray = {pending_gray, gray_for_depth(d)};
		end
	endtask

	// Offers one request, possibly after a few idle cycles, and returns once the
	// block has taken it. Valid stays high into the next request unless that
	// request starts with a gap, so back-to-back requests see no dip.
	task automatic send_request(dmg_pkg::op_t op, logic restart, logic [15:0] d);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 22) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		first <= restart;
		depth <= d;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		track_request(op, restart, d);
		request_count++;
	endtask

	// Receiver: ready changes at the falling edge, either held low for a counted
	// stretch or dropped at random with a chance of about 22 in a hundred.
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= no_idle || ($urandom_range(0, 99) >= 22);
			end
		end
	end

	// Result checker: every accepted result is matched with the oldest pending
	// gray level.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_gray.size() == 0) begin
				$display("%0t: unexpected gray result, expected none, actual %0d",
					$time, gray);
				error_count++;
			end else begin
				if (gray !== pending_gray[0]) begin
					$display("%0t: gray mismatch, expected %0d, actual %0d",
						$time, pending_gray[0], gray);
					error_count++;
				end
				void'(pending_gray.pop_front());
			end
		end
	end

	// Before any scan the range is empty, so every nonzero sample is white.
	task automatic test_unscanned_range();
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd0);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd1);
		send_request(dmg_pkg::OP_MAP, 1'b1, 16'hFFFF);
	endtask

	// Full range from 1 to all ones, with an empty scan sample and extreme maps.
	task automatic test_full_range();
		send_request(dmg_pkg::OP_SCAN, 1'b1, 16'd1);
		send_request(dmg_pkg::OP_SCAN, 1'b0, 16'hFFFF);
		send_request(dmg_pkg::OP_SCAN, 1'b0, 16'd0);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd0);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd1);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd2);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'h8000);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'hFFFE);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'hFFFF);
	endtask

	// Restart on an empty sample, a single-valued range, then clamping below
	// the minimum and above the maximum with a first flag on a map request.
	task automatic test_range_corners();
		send_request(dmg_pkg::OP_SCAN, 1'b1, 16'd0);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd500);
		send_request(dmg_pkg::OP_SCAN, 1'b1, 16'd1000);
		send_request(dmg_pkg::OP_SCAN, 1'b0, 16'd1000);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd1000);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd999);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd1001);
		send_request(dmg_pkg::OP_SCAN, 1'b0, 16'd2000);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd500);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd3000);
		send_request(dmg_pkg::OP_MAP, 1'b1, 16'd1500);
		send_request(dmg_pkg::OP_MAP, 1'b0, 16'd1001);
	endtask

	// Random frames: a scan pass followed by a map pass, over ranges that are
	// full, narrow, medium or reaching the top. Now and then a scan pass is
	// left out or lacks its restart, and some samples fall outside the range.
	task automatic test_random_frames(int unsigned target);
		int unsigned scans;
		int unsigned maps;
		int unsigned base;
		int unsigned top;
		int unsigned pick;
		logic [15:0] d;
		logic restart;
		while (request_count < target) begin
			scans = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
			maps = $urandom_range(1, 40);
			case ($urandom_range(0, 3))
				0: begin
					base = 1;
					top = 65535;
				end
				1: begin
					base = $urandom_range(1, 65535);
					top = base + $urandom_range(0, 20);
				end
				2: begin
					base = $urandom_range(1, 60000);
					top = base + $urandom_range(0, 5000);
				end
				default: begin
					base = $urandom_range(1, 65535);
					top = 65535;
				end
			endcase
			if (top > 65535)
				top = 65535;
			for (int i = 0; i < scans; i++) begin
				restart = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
				d = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(top, base));
				send_request(dmg_pkg::OP_SCAN, restart, d);
			end
			for (int i = 0; i < maps; i++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					d = 16'd0;
				else if (pick == 1)
					d = 16'($urandom_range(0, 65535));
				else if (pick == 2)
					d = 16'(base - 1);
				else if (pick == 3)
					d = 16'((top == 65535) ? top : top + 1);
				else
					d = 16'($urandom_range(top, base));
				send_request(dmg_pkg::OP_MAP, 1'($urandom_range(0, 1)), d);
			end
		end
	endtask

	// A stretch of frames with neither side idling, so requests run back to back.
	task automatic test_back_to_back();
		no_idle = 1'b1;
		test_random_frames(request_count + 200);
		no_idle = 1'b0;
	endtask

	// The receiver holds off for a long stretch while map requests keep coming,
	// so the block fills up and has to stall its input.
	task automatic test_output_backpressure();
		send_request(dmg_pkg::OP_SCAN, 1'b1, 16'($urandom_range(1, 65535)));
		send_request(dmg_pkg::OP_SCAN, 1'b0, 16'($urandom_range(1, 65535)));
		hold_left = HOLD_OFF_CYCLES;
		for (int i = 0; i < 60; i++)
			send_request(dmg_pkg::OP_MAP, 1'b0, 16'($urandom_range(0, 65535)));
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		operation = dmg_pkg::OP_SCAN;
		first = 1'b0;
		depth = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_unscanned_range();
		test_full_range();
		test_range_corners();
		test_back_to_back();
		test_output_backpressure();
		test_random_frames(REQUEST_TARGET);

		// All requests are in; let the block drain, then give stray results a chance.
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_gray.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: a correct run ends far sooner than this.
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
